// File: rtl/psa_pkg.sv
// Shared constants and types for the paged slot allocator.
`timescale 1ns / 1ps
`default_nettype none
package psa_pkg;

  localparam int SLOTS_PER_PAGE = 256;
  localparam int MAX_PAGES      = 16;
  localparam int TOTAL_SLOTS    = SLOTS_PER_PAGE * MAX_PAGES;

  localparam int SLOT_W     = $clog2(SLOTS_PER_PAGE);
  localparam int PAGE_W     = $clog2(MAX_PAGES);
  localparam int CNT_W      = SLOT_W + 1;
  localparam int PAGE_IDX_W = PAGE_W + 1;
  localparam int HANDLE_W   = 12;
  localparam int LIVE_W     = 13;
  localparam int ENTRY_W    = CNT_W + 1;
  localparam int USED_BIT   = CNT_W;

  localparam logic [PAGE_IDX_W-1:0] NO_PAGE  = PAGE_IDX_W'(MAX_PAGES);
  localparam logic [CNT_W-1:0]      PAGE_CAP = CNT_W'(SLOTS_PER_PAGE);

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_EXHAUSTED = 2'd1;
  localparam status_t ST_NO_PAGE   = 2'd2;
  localparam status_t ST_NOT_LIVE  = 2'd3;

  typedef logic [ENTRY_W-1:0] slot_entry_t;

endpackage
`default_nettype wire

// File: rtl/psa_ram.sv
// Generic single-port-write RAM with one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module psa_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/paged_slot_allocator.sv
// Paged slot allocator: per-page LIFO free lists and a list of pages with free slots.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+---------------------------------------------
//  command   | start, busy           | op, slot_handle_in
//  result    | done (one-cycle pulse)| slot_handle_out, status, live_orders
//
//  The slot memory read issues in the accept cycle, and in the next cycle the
//  transaction checks, writes back and updates the page table. busy is high
//  for that cycle only; the result shows in the cycle after, while the next
//  transaction may already be accepted.
//  Synchronous reset; no clearing pass: per-page fill counts mark untouched slots.
//  The receiver cannot stall; results are never held.
`timescale 1ns / 1ps
`default_nettype none
module paged_slot_allocator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           op,
  input  logic [psa_pkg::HANDLE_W-1:0]   slot_handle_in,
  output logic                           done,
  output logic [psa_pkg::HANDLE_W-1:0]   slot_handle_out,
  output psa_pkg::status_t               status,
  output logic [psa_pkg::LIVE_W-1:0]     live_orders
);
  import psa_pkg::*;

  logic [CNT_W-1:0]      first_free [MAX_PAGES];
  logic [CNT_W-1:0]      free_count [MAX_PAGES];
  logic [CNT_W-1:0]      fill       [MAX_PAGES];
  logic [PAGE_IDX_W-1:0] page_next  [MAX_PAGES];
  logic [PAGE_IDX_W-1:0] list_head;
  logic [PAGE_IDX_W-1:0] pages_made;
  logic [LIVE_W-1:0]     live_total;

  logic                  accept;
  logic [PAGE_W-1:0]     issue_page;
  logic [SLOT_W-1:0]     issue_slot;
  logic                  issue_new;
  status_t               issue_status;

  logic                  cur_op;
  logic [PAGE_W-1:0]     cur_page;
  logic [SLOT_W-1:0]     cur_slot;
  logic                  cur_new;
  status_t               cur_status;

  slot_entry_t           rd_entry;
  slot_entry_t           wr_entry;
  logic                  fresh;
  logic                  slot_live;
  status_t               final_status;
  logic                  commit;
  logic [CNT_W-1:0]      cnt;
  logic [LIVE_W-1:0]     live_next;

  assign accept = start && !busy;

  always_comb begin
    issue_page   = slot_handle_in[SLOT_W +: PAGE_W];
    issue_slot   = slot_handle_in[SLOT_W-1:0];
    issue_new    = 1'b0;
    issue_status = ST_OK;
    if (op == OP_ALLOC) begin
      if (list_head != NO_PAGE) begin
        issue_page = list_head[PAGE_W-1:0];
      end else if (pages_made != NO_PAGE) begin
        issue_page = pages_made[PAGE_W-1:0];
        issue_new  = 1'b1;
      end else begin
        issue_status = ST_EXHAUSTED;
      end
      issue_slot = first_free[issue_page][SLOT_W-1:0];
    end else if ({1'b0, issue_page} >= pages_made) begin
      issue_status = ST_NO_PAGE;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_op     <= op;
      cur_page   <= issue_page;
      cur_slot   <= issue_slot;
      cur_new    <= issue_new;
      cur_status <= issue_status;
    end
  end

  psa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TOTAL_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (commit),
    .waddr ({cur_page, cur_slot}),
    .wdata (wr_entry),
    .raddr ({issue_page, issue_slot}),
    .rdata (rd_entry)
  );

  always_comb begin
    cnt       = free_count[cur_page];
    fresh     = {1'b0, cur_slot} >= fill[cur_page];
    slot_live = !fresh && rd_entry[USED_BIT];
    final_status = cur_status;
    if (cur_status == ST_OK && cur_op == OP_RELEASE && !slot_live) begin
      final_status = ST_NOT_LIVE;
    end
    commit    = busy && (final_status == ST_OK);
    wr_entry  = (cur_op == OP_RELEASE) ? {1'b0, first_free[cur_page]}
                                       : {1'b1, {CNT_W{1'b0}}};
    live_next = live_total;
    if (commit) begin
      live_next = (cur_op == OP_RELEASE) ? live_total - LIVE_W'(1)
                                         : live_total + LIVE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      done       <= 1'b0;
      list_head  <= NO_PAGE;
      pages_made <= '0;
      live_total <= '0;
      for (int i = 0; i < MAX_PAGES; i++) begin
        first_free[i] <= '0;
        free_count[i] <= PAGE_CAP;
        fill[i]       <= '0;
        page_next[i]  <= NO_PAGE;
      end
    end else begin
      busy       <= accept;
      done       <= busy;
      live_total <= live_next;
      if (commit) begin
        if (cur_op == OP_ALLOC) begin
          first_free[cur_page] <= fresh ? {1'b0, cur_slot} + CNT_W'(1)
                                        : rd_entry[CNT_W-1:0];
          free_count[cur_page] <= cnt - CNT_W'(1);
          if (fresh) begin
            fill[cur_page] <= fill[cur_page] + CNT_W'(1);
          end
          if (cur_new) begin
            pages_made <= pages_made + PAGE_IDX_W'(1);
          end
          if (cnt == CNT_W'(1)) begin
            list_head           <= page_next[cur_page];
            page_next[cur_page] <= NO_PAGE;
          end else if (cur_new) begin
            list_head <= {1'b0, cur_page};
          end
        end else begin
          first_free[cur_page] <= {1'b0, cur_slot};
          free_count[cur_page] <= cnt + CNT_W'(1);
          if (cnt == '0) begin
            page_next[cur_page] <= list_head;
            list_head           <= {1'b0, cur_page};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      slot_handle_out <= (final_status == ST_EXHAUSTED) ? '0 : {cur_page, cur_slot};
      status          <= final_status;
      live_orders     <= live_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/psa_checker.sv
// Port-level checks for the paged slot allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module psa_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         op,
  input logic [psa_pkg::HANDLE_W-1:0] slot_handle_in,
  input logic                         done,
  input logic [psa_pkg::HANDLE_W-1:0] slot_handle_out,
  input psa_pkg::status_t             status,
  input logic [psa_pkg::LIVE_W-1:0]   live_orders
);
  import psa_pkg::*;

  a_busy_one_cycle: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("accepted transaction produced no result two cycles later");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a transaction in flight");

  a_exhausted_full: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_EXHAUSTED) |->
      (live_orders == LIVE_W'(TOTAL_SLOTS) && slot_handle_out == '0))
    else $error("pool exhausted reported while slots remain");

endmodule

bind paged_slot_allocator psa_checker u_psa_checker (.*);
`default_nettype wire

// File: tb/tb_paged_slot_allocator.sv
// Self-checking testbench for paged_slot_allocator: directed and random transactions, scoreboard.
`timescale 1ns / 1ps
module tb_paged_slot_allocator;
  import psa_pkg::*;

  typedef struct {
    logic [HANDLE_W-1:0] handle;
    status_t             st;
    logic [LIVE_W-1:0]   live;
  } reply_t;

  class slot_pool_tracker;
    logic [CNT_W-1:0]      slot_link [TOTAL_SLOTS];
    bit                    slot_taken [TOTAL_SLOTS];
    logic [CNT_W-1:0]      page_head_slot [MAX_PAGES];
    logic [CNT_W-1:0]      page_free [MAX_PAGES];
    logic [PAGE_IDX_W-1:0] page_prev [MAX_PAGES];
    logic [PAGE_IDX_W-1:0] page_next [MAX_PAGES];
    bit                    page_on_list [MAX_PAGES];
    logic [PAGE_IDX_W-1:0] list_head;
    logic [PAGE_IDX_W-1:0] pages_open;
    logic [LIVE_W-1:0]     live_total;
    int                    live_handles[$];
    reply_t                replies_due[$];
    int                    mismatches;

    function new();
      for (int i = 0; i < TOTAL_SLOTS; i++) begin
        slot_link[i]  = CNT_W'((i % SLOTS_PER_PAGE) + 1);
        slot_taken[i] = 1'b0;
      end
      for (int i = 0; i < MAX_PAGES; i++) begin
        page_head_slot[i] = '0;
        page_free[i]      = PAGE_CAP;
        page_prev[i]      = NO_PAGE;
        page_next[i]      = NO_PAGE;
        page_on_list[i]   = 1'b0;
      end
      list_head  = NO_PAGE;
      pages_open = '0;
      live_total = '0;
      mismatches = 0;
    endfunction

    function void link_page(int p);
      if (page_on_list[p]) return;
      page_prev[p] = NO_PAGE;
      page_next[p] = list_head;
      if (list_head != NO_PAGE) page_prev[list_head] = PAGE_IDX_W'(p);
      list_head = PAGE_IDX_W'(p);
      page_on_list[p] = 1'b1;
    endfunction

    function void unlink_page(int p);
      logic [PAGE_IDX_W-1:0] pv;
      logic [PAGE_IDX_W-1:0] nx;
      if (!page_on_list[p]) return;
      pv = page_prev[p];
      nx = page_next[p];
      if (pv != NO_PAGE) page_next[pv] = nx;
      else list_head = nx;
      if (nx != NO_PAGE) page_prev[nx] = pv;
      page_prev[p] = NO_PAGE;
      page_next[p] = NO_PAGE;
      page_on_list[p] = 1'b0;
    endfunction

    function void forget_handle(int g);
      for (int i = 0; i < live_handles.size(); i++) begin
        if (live_handles[i] == g) begin
          live_handles[i] = live_handles[live_handles.size() - 1];
          live_handles.delete(live_handles.size() - 1);
          return;
        end
      end
    endfunction

    function void accept_cmd(logic cmd_op, logic [HANDLE_W-1:0] cmd_handle);
      reply_t r;
      int p;
      int s;
      int g;
      r.handle = cmd_handle;
      r.st = ST_OK;
      if (cmd_op == OP_ALLOC) begin
        r.handle = '0;
        p = int'(list_head);
        if (list_head == NO_PAGE) begin
          if (int'(pages_open) >= MAX_PAGES) begin
            r.st = ST_EXHAUSTED;
          end else begin
            p = int'(pages_open);
            pages_open = pages_open + 1'b1;
            link_page(p);
          end
        end
        if (r.st == ST_OK) begin
          s = int'(page_head_slot[p][SLOT_W-1:0]);
          g = p * SLOTS_PER_PAGE + s;
          page_head_slot[p] = slot_link[g];
          if (page_free[p] != 0) page_free[p] = page_free[p] - 1'b1;
          slot_taken[g] = 1'b1;
          if (page_free[p] == 0) unlink_page(p);
          live_total = live_total + 1'b1;
          r.handle = HANDLE_W'(g);
          live_handles.insert(live_handles.size(), g);
        end
      end else begin
        g = int'(cmd_handle);
        p = g / SLOTS_PER_PAGE;
        s = g % SLOTS_PER_PAGE;
        if (p >= int'(pages_open) || p >= MAX_PAGES) begin
          r.st = ST_NO_PAGE;
        end else if (!slot_taken[g]) begin
          r.st = ST_NOT_LIVE;
        end else begin
          slot_taken[g] = 1'b0;
          slot_link[g] = page_head_slot[p];
          page_head_slot[p] = CNT_W'(s);
          if (page_free[p] == 0) link_page(p);
          page_free[p] = page_free[p] + 1'b1;
          if (live_total != 0) live_total = live_total - 1'b1;
          forget_handle(g);
        end
      end
      r.live = live_total;
      replies_due.insert(replies_due.size(), r);
    endfunction

    function void match_reply(logic [HANDLE_W-1:0] h, status_t st, logic [LIVE_W-1:0] live);
      reply_t r;
      if (replies_due.size() == 0) begin
        $display("%0t: reply with none pending: handle %0d status %0d live %0d",
                 $time, h, st, live);
        mismatches++;
        return;
      end
      r = replies_due.pop_front();
      if (h !== r.handle) begin
        $display("%0t: slot_handle_out expected %0d actual %0d", $time, r.handle, h);
        mismatches++;
      end
      if (st !== r.st) begin
        $display("%0t: status expected %0d actual %0d", $time, r.st, st);
        mismatches++;
      end
      if (live !== r.live) begin
        $display("%0t: live_orders expected %0d actual %0d", $time, r.live, live);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                op = OP_ALLOC;
  logic [HANDLE_W-1:0] slot_handle_in = '0;
  logic                busy;
  logic                done;
  logic [HANDLE_W-1:0] slot_handle_out;
  status_t             status;
  logic [LIVE_W-1:0]   live_orders;

  slot_pool_tracker tracker = new();
  int idle_pct = 28;

  paged_slot_allocator dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .op             (op),
    .slot_handle_in (slot_handle_in),
    .done           (done),
    .slot_handle_out(slot_handle_out),
    .status         (status),
    .live_orders    (live_orders)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done) tracker.match_reply(slot_handle_out, status, live_orders);
  end

  task automatic push_cmd(input logic cmd_op, input logic [HANDLE_W-1:0] cmd_handle);
    start <= 1'b1;
    op <= cmd_op;
    slot_handle_in <= cmd_handle;
    @(posedge clk);
    while (busy) @(posedge clk);
    tracker.accept_cmd(cmd_op, cmd_handle);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (tracker.replies_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic random_mix(input int count, input int alloc_pct, input int release_pct);
    int r;
    int span;
    logic [HANDLE_W-1:0] h;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      h = HANDLE_W'($urandom_range(0, 4095));
      if (r < alloc_pct) begin
        push_cmd(OP_ALLOC, h);
      end else if (r < alloc_pct + release_pct && tracker.live_handles.size() != 0) begin
        h = HANDLE_W'(tracker.live_handles[
              $urandom_range(0, tracker.live_handles.size() - 1)]);
        push_cmd(OP_RELEASE, h);
      end else begin
        span = int'(tracker.pages_open) * SLOTS_PER_PAGE;
        if (span != 0 && $urandom_range(0, 1) == 1)
          h = HANDLE_W'($urandom_range(0, span - 1));
        push_cmd(OP_RELEASE, h);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    push_cmd(OP_RELEASE, 12'd0);
    push_cmd(OP_RELEASE, 12'd4095);
    push_cmd(OP_ALLOC, 12'd4095);
    push_cmd(OP_ALLOC, 12'd0);
    push_cmd(OP_RELEASE, 12'd0);
    push_cmd(OP_RELEASE, 12'd0);
    push_cmd(OP_RELEASE, 12'd255);
    push_cmd(OP_RELEASE, 12'd256);
    push_cmd(OP_ALLOC, 12'd2730);
    push_cmd(OP_RELEASE, 12'd1);
    push_cmd(OP_RELEASE, 12'd0);
    push_cmd(OP_ALLOC, 12'd1365);
    push_cmd(OP_ALLOC, 12'd0);
    push_cmd(OP_RELEASE, 12'd2048);
    drain();

    random_mix(150, 65, 25);
    drain();

    idle_pct = 0;
    while (tracker.live_handles.size() < SLOTS_PER_PAGE + SLOTS_PER_PAGE / 4)
      push_cmd(OP_ALLOC, HANDLE_W'($urandom_range(0, 4095)));
    repeat (3) push_cmd(OP_ALLOC, HANDLE_W'($urandom_range(0, 4095)));
    push_cmd(OP_RELEASE, 12'd4095);
    push_cmd(OP_RELEASE, 12'd4095);
    idle_pct = 28;
    drain();

    random_mix(350, 45, 40);
    drain();

    if (tracker.mismatches == 0 && tracker.replies_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
